// ===== rtl/core/mbt_pkg.sv =====
// Shared types and constants for the motor button toggle timeout block.
package mbt_pkg;

  // Fixed field widths
  localparam int unsigned TIME_MS_W   = 32;
  localparam int unsigned LIMIT_W     = 22;
  localparam int unsigned PRESS_W     = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 22;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST  = 22'd35000;
  localparam logic [LIMIT_W-1:0] WARN_WINDOW_RST = 22'd3000;
  localparam logic [PRESS_W-1:0] MIN_PRESS_RST  = 10'd50;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_LIMIT   = 2'd0,
    CFG_WARN_WINDOW = 2'd1,
    CFG_MIN_PRESS   = 2'd2
  } cfg_idx_t;

  // Motor drive codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

endpackage

// ===== rtl/core/mbt_if.sv =====
// Valid/ready channel interfaces for poll items and result items.
interface mbt_in_if import mbt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIME_MS_W-1:0] time_ms;
  logic                 fwd_pressed;
  logic                 rev_pressed;

  modport source (output valid, time_ms, fwd_pressed, rev_pressed, input ready);
  modport sink   (input valid, time_ms, fwd_pressed, rev_pressed, output ready);
endinterface

interface mbt_out_if import mbt_pkg::*; ();
  logic valid;
  logic ready;
  dir_t motor_dir;
  logic led_forward;
  logic led_reverse;
  logic near_limit_warn;
  logic timed_out;

  modport source (output valid, motor_dir, led_forward, led_reverse, near_limit_warn,
                  timed_out, input ready);
  modport sink   (input valid, motor_dir, led_forward, led_reverse, near_limit_warn,
                  timed_out, output ready);
endinterface

// ===== rtl/core/motor_button_toggle_timeout_top.sv =====
// Motor direction toggle with press qualification and run-time limit.
// A poll passes through the input register and then the result register.
// Throughput: one poll per cycle while out_if.ready holds; the state update is a single subtract/compare pass.
// A stalled result register holds the input register, which then holds in_if.ready low.
// Reset (synchronous, rst_n low): motor stopped, toggle armed, no qualification,
// registers back to 35000 / 3000 / 50 ms, both pipeline stages empty.
module motor_button_toggle_timeout_top import mbt_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mbt_in_if.sink                in_if,
  mbt_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Compare width covering both elapsed time and the limit
  localparam int unsigned CW = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  // Configuration registers
  logic [LIMIT_W-1:0] run_limit_r;
  logic [LIMIT_W-1:0] warn_window_r;
  logic [PRESS_W-1:0] min_press_r;

  // Input stage
  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic                 s1_fwd_r;
  logic                 s1_rev_r;
  logic [TIME_BITS-1:0] in_time;

  // Control state
  dir_t                 direction_r,     direction_nxt;
  logic                 running_r,       running_nxt;
  logic [TIME_BITS-1:0] run_start_r,     run_start_nxt;
  logic                 qualifying_r,    qualifying_nxt;
  logic [TIME_BITS-1:0] qualify_start_r, qualify_start_nxt;
  dir_t                 candidate_r,     candidate_nxt;
  logic                 armed_r,         armed_nxt;

  // Result stage
  logic out_valid_r;
  dir_t out_dir_r;
  logic out_warn_r;
  logic out_tmo_r;

  // Per-item working values
  logic                 advance;
  logic                 fire;
  logic [TIME_BITS-1:0] on_time;
  logic [TIME_BITS-1:0] held_time;
  logic [CW-1:0]        on_x;
  logic [CW-1:0]        limit_x;
  logic [CW-1:0]        wstart_x;
  logic [LIMIT_W-1:0]   wstart;
  logic                 warn_hit;
  logic                 tmo;
  dir_t                 pushed;
  logic                 held_short;

  // Truncate or zero-extend the timestamp to the time base width
  generate
    if (TIME_BITS <= TIME_MS_W) begin : g_time_trunc
      assign in_time = in_if.time_ms[TIME_BITS-1:0];
    end else begin : g_time_ext
      assign in_time = {{(TIME_BITS-TIME_MS_W){1'b0}}, in_if.time_ms};
    end
  endgenerate

  // Handshake: the input stage moves whenever the result register frees up
  assign advance     = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && advance;
  assign in_if.ready = !s1_valid_r || advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r   <= RUN_LIMIT_RST;
      warn_window_r <= WARN_WINDOW_RST;
      min_press_r   <= MIN_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RUN_LIMIT:   run_limit_r   <= cfg_wdata;
        CFG_WARN_WINDOW: warn_window_r <= cfg_wdata;
        CFG_MIN_PRESS:   min_press_r   <= cfg_wdata[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // Load the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_time_r <= in_time;
      s1_fwd_r  <= in_if.fwd_pressed;
      s1_rev_r  <= in_if.rev_pressed;
    end
  end

  // Run-time window check
  always_comb begin
    on_time  = s1_time_r - run_start_r;
    on_x     = CW'(on_time);
    limit_x  = CW'(run_limit_r);
    wstart   = (run_limit_r > warn_window_r) ? (run_limit_r - warn_window_r) : '0;
    wstart_x = CW'(wstart);
    warn_hit = running_r && (on_x <= limit_x) && (on_x >= wstart_x);
    tmo      = running_r && (on_x > limit_x);
  end

  // Button priority and hold time
  always_comb begin
    if (s1_rev_r) begin
      pushed = DIR_REV;
    end else if (s1_fwd_r) begin
      pushed = DIR_FWD;
    end else begin
      pushed = DIR_STOP;
    end
    held_time  = s1_time_r - qualify_start_r;
    held_short = held_time < TIME_BITS'(min_press_r);
  end

  // Next control state for the item in the input stage
  always_comb begin
    direction_nxt     = direction_r;
    running_nxt       = running_r;
    run_start_nxt     = run_start_r;
    qualifying_nxt    = qualifying_r;
    qualify_start_nxt = qualify_start_r;
    candidate_nxt     = candidate_r;
    armed_nxt         = armed_r;
    if (tmo) begin
      // Stop on run limit, ignore buttons this poll
      direction_nxt = DIR_STOP;
      running_nxt   = 1'b0;
    end else if (!qualifying_r || (candidate_r != pushed)) begin
      // Restart qualification on a changed button state
      qualifying_nxt    = 1'b1;
      qualify_start_nxt = s1_time_r;
      candidate_nxt     = pushed;
    end else if (!held_short) begin
      qualifying_nxt = 1'b0;
      if (pushed == DIR_STOP) begin
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        armed_nxt = 1'b0;
        if (direction_r == pushed) begin
          direction_nxt = DIR_STOP;
          running_nxt   = 1'b0;
        end else begin
          direction_nxt = pushed;
          running_nxt   = 1'b1;
          run_start_nxt = s1_time_r;
        end
      end
    end
  end

  // Commit control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r     <= DIR_STOP;
      running_r       <= 1'b0;
      run_start_r     <= '0;
      qualifying_r    <= 1'b0;
      qualify_start_r <= '0;
      candidate_r     <= DIR_STOP;
      armed_r         <= 1'b1;
    end else if (fire) begin
      direction_r     <= direction_nxt;
      running_r       <= running_nxt;
      run_start_r     <= run_start_nxt;
      qualifying_r    <= qualifying_nxt;
      qualify_start_r <= qualify_start_nxt;
      candidate_r     <= candidate_nxt;
      armed_r         <= armed_nxt;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_dir_r  <= direction_nxt;
      out_warn_r <= warn_hit;
      out_tmo_r  <= tmo;
    end
  end

  // Drive the result channel
  assign out_if.valid           = out_valid_r;
  assign out_if.motor_dir       = out_dir_r;
  assign out_if.led_forward     = (out_dir_r == DIR_FWD);
  assign out_if.led_reverse     = (out_dir_r == DIR_REV);
  assign out_if.near_limit_warn = out_warn_r;
  assign out_if.timed_out       = out_tmo_r;

`ifndef SYNTHESIS
  // Running flag tracks a non-stop direction
  a_run_dir: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (direction_r != DIR_STOP))
    else $error("running flag out of step with direction");

  // A timeout leaves the motor stopped
  a_tmo_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && tmo) |=> (!running_r && (direction_r == DIR_STOP)))
    else $error("motor not stopped after run limit");

  // Warning and timeout never share a result item
  a_warn_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_warn_r && out_tmo_r))
    else $error("warning and timeout both set");

  // A start records the poll timestamp
  a_start_time: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !running_r && running_nxt) |=> (run_start_r == $past(s1_time_r)))
    else $error("run start not captured");
`endif

endmodule
